[hw/rtl/i2cm_pkg.sv]
`timescale 1ns / 1ps

package i2cm_pkg;

  // command codes
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_WRITE     = 3'd3;
  localparam logic [2:0] CMD_READ_ACK  = 3'd4;
  localparam logic [2:0] CMD_READ_NACK = 3'd5;

  localparam logic [7:0] TICKS_RESET = 8'd100;
  localparam logic [3:0] BYTE_BITS   = 4'd8;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    ST_SDA1  = 5'd1,
    ST_SCL1  = 5'd2,
    ST_SDA0  = 5'd3,
    ST_SCL0  = 5'd4,
    SP_SCL0  = 5'd5,
    SP_SDA0  = 5'd6,
    SP_SCL1  = 5'd7,
    SP_SDA1  = 5'd8,
    WB_SCL0  = 5'd9,
    WB_SDA   = 5'd10,
    WB_SCL1  = 5'd11,
    WA_SCL0  = 5'd12,
    WA_SDA1  = 5'd13,
    WA_SCL1  = 5'd14,
    RB_SCL0  = 5'd15,
    RB_SCL1  = 5'd16,
    RA_SCL0  = 5'd17,
    RA_SDA   = 5'd18,
    RA_SCL1  = 5'd19,
    RA_SCL0B = 5'd20
  } phase_t;

  // one result transaction
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       start_failed;
  } res_t;

endpackage

[hw/rtl/i2cm_seq.sv]
`timescale 1ns / 1ps

module i2cm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic [2:0]      command,
  input  logic [7:0]      tx_byte,
  input  logic            sda_in,
  output i2cm_pkg::res_t  res
);
  import i2cm_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] ticks_r;
  logic [7:0] tick_r, tick_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [2:0] active_r, active_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_r, ack_nxt;
  logic       fail_r, fail_nxt;
  logic [7:0] rx_r, rx_nxt;

  logic [7:0] lim;
  logic       is_idle;
  logic       cmd_ok;
  logic       phase_end;
  logic       enter;
  logic       done;
  logic [3:0] bit_inc;
  logic [7:0] shift_in;

  assign lim       = (ticks_r == 8'd0) ? 8'd1 : ticks_r;
  assign is_idle   = (phase_r == PH_IDLE);
  assign cmd_ok    = (command >= CMD_START) && (command <= CMD_READ_NACK);
  assign phase_end = !is_idle && (tick_r >= lim);
  assign bit_inc   = bit_r + 4'd1;
  assign shift_in  = {shift_r[6:0], sda_in};

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    enter     = 1'b0;
    done      = 1'b0;
    if (is_idle) begin
      if (cmd_ok) begin
        enter = 1'b1;
        if (command == CMD_START) begin
          phase_nxt = ST_SDA1;
        end else if (command == CMD_STOP) begin
          phase_nxt = SP_SCL0;
        end else if (command == CMD_WRITE) begin
          phase_nxt = WB_SCL0;
        end else begin
          phase_nxt = RB_SCL0;
        end
      end
    end else if (phase_end) begin
      enter = 1'b1;
      unique case (phase_r)
        ST_SDA1: phase_nxt = ST_SCL1;
        ST_SCL1: begin
          if (!sda_in) begin
            phase_nxt = PH_IDLE;
            enter     = 1'b0;
            done      = 1'b1;
          end else begin
            phase_nxt = ST_SDA0;
          end
        end
        ST_SDA0: phase_nxt = ST_SCL0;
        SP_SCL0: phase_nxt = SP_SDA0;
        SP_SDA0: phase_nxt = SP_SCL1;
        SP_SCL1: phase_nxt = SP_SDA1;
        WB_SCL0: phase_nxt = WB_SDA;
        WB_SDA:  phase_nxt = WB_SCL1;
        WB_SCL1: phase_nxt = (bit_inc < BYTE_BITS) ? WB_SCL0 : WA_SCL0;
        WA_SCL0: phase_nxt = WA_SDA1;
        WA_SDA1: phase_nxt = WA_SCL1;
        RB_SCL0: phase_nxt = RB_SCL1;
        RB_SCL1: phase_nxt = (bit_inc < BYTE_BITS) ? RB_SCL0 : RA_SCL0;
        RA_SCL0: phase_nxt = RA_SDA;
        RA_SDA:  phase_nxt = RA_SCL1;
        RA_SCL1: phase_nxt = RA_SCL0B;
        default: begin
          // last phase of start, stop, write ack and read ack
          phase_nxt = PH_IDLE;
          enter     = 1'b0;
          done      = 1'b1;
        end
      endcase
    end
  end

  // lines, counters and status
  always_comb begin
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    active_nxt = active_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    ack_nxt    = ack_r;
    fail_nxt   = fail_r;
    rx_nxt     = rx_r;

    if (is_idle) begin
      if (cmd_ok) begin
        active_nxt = command;
        bit_nxt    = 4'd0;
        if (command == CMD_WRITE) begin
          shift_nxt = tx_byte;
        end else if (command == CMD_READ_ACK || command == CMD_READ_NACK) begin
          sda_nxt   = 1'b1;
          shift_nxt = 8'd0;
        end
      end
    end else if (!phase_end) begin
      tick_nxt = tick_r + 8'd1;
    end else begin
      case (phase_r)
        ST_SCL1: fail_nxt = !sda_in;
        WB_SCL1: bit_nxt = bit_inc;
        WA_SCL1: begin
          ack_nxt = !sda_in;
          scl_nxt = 1'b0;
        end
        RB_SCL1: begin
          shift_nxt = shift_in;
          bit_nxt   = bit_inc;
          if (bit_inc >= BYTE_BITS) begin
            rx_nxt = shift_in;
          end
        end
        default: ;
      endcase
    end

    if (enter) begin
      tick_nxt = 8'd1;
      case (phase_nxt)
        ST_SDA1, SP_SDA1, WA_SDA1: sda_nxt = 1'b1;
        ST_SDA0, SP_SDA0:          sda_nxt = 1'b0;
        ST_SCL1, SP_SCL1, WB_SCL1, WA_SCL1, RB_SCL1, RA_SCL1: scl_nxt = 1'b1;
        ST_SCL0, SP_SCL0, WB_SCL0, WA_SCL0, RB_SCL0, RA_SCL0, RA_SCL0B: scl_nxt = 1'b0;
        WB_SDA: begin
          sda_nxt   = shift_r[7];
          shift_nxt = {shift_r[6:0], 1'b0};
        end
        RA_SDA: sda_nxt = (active_r != CMD_READ_ACK);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      ticks_r  <= TICKS_RESET;
      tick_r   <= 8'd0;
      bit_r    <= 4'd0;
      shift_r  <= 8'd0;
      active_r <= CMD_NONE;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      ack_r    <= 1'b0;
      fail_r   <= 1'b0;
      rx_r     <= 8'd0;
    end else begin
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
      if (step) begin
        phase_r  <= phase_nxt;
        tick_r   <= tick_nxt;
        bit_r    <= bit_nxt;
        shift_r  <= shift_nxt;
        active_r <= active_nxt;
        scl_r    <= scl_nxt;
        sda_r    <= sda_nxt;
        ack_r    <= ack_nxt;
        fail_r   <= fail_nxt;
        rx_r     <= rx_nxt;
      end
    end
  end

  always_comb begin
    res.scl_level    = scl_nxt;
    res.sda_level    = sda_nxt;
    res.ready_res    = is_idle;
    res.done_res     = done;
    res.rx_byte      = rx_nxt;
    res.ack_received = ack_nxt;
    res.start_failed = fail_nxt;
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && done |=> phase_r == PH_IDLE)
    else $error("finished command did not return to idle");

  a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_idle && cmd_ok |=> phase_r != PH_IDLE)
    else $error("accepted command did not start a phase");

  a_busy_tick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> tick_r != 8'd0)
    else $error("busy phase with zero tick count");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= BYTE_BITS)
    else $error("bit counter past one byte");

endmodule

[hw/rtl/i2cm_obuf.sv]
`timescale 1ns / 1ps

module i2cm_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  i2cm_pkg::res_t  res_in,
  input  logic            out_stall,
  output logic            out_valid,
  output logic            busy,
  output i2cm_pkg::res_t  res_out
);
  import i2cm_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign busy      = valid_r && out_stall;
  assign valid_nxt = load || busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

  a_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> valid_r && $stable(res_r))
    else $error("stalled result changed or dropped");

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !load)
    else $error("result register overwritten while stalled");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not presented");

endmodule

[hw/rtl/i2c_master_byte_engine.sv]
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  in_command, in_tx_byte, in_sda_in
// out_      output     out_valid/out_stall  out_scl_level .. out_start_failed
// cfg_      input      cfg_we               cfg_wdata (phase_ticks)
//
// one tick transaction in, one result transaction out; the result is registered
// a transaction can be taken every cycle while in_stall is low; the phase sequencer updates in a single pass
// in_stall follows out_stall only while the result register is full and stalled
// synchronous active-low reset: idle, lines released, phase_ticks back to 100
// bus timing is counted in accepted transactions, not in clock cycles
module i2c_master_byte_engine (
  input  logic       clk,
  input  logic       rst_n,
  // tick input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [7:0] in_tx_byte,
  input  logic       in_sda_in,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_ready_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_ack_received,
  output logic       out_start_failed,
  // phase length register
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import i2cm_pkg::*;

  logic accept;
  logic obuf_busy;
  res_t seq_res;
  res_t out_res;

  // a new tick is taken whenever the result register can be refilled
  assign in_stall = obuf_busy;
  assign accept   = in_valid && !obuf_busy;

  // phase sequencer: state advances only on an accepted tick
  i2cm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .command   (in_command),
    .tx_byte   (in_tx_byte),
    .sda_in    (in_sda_in),
    .res       (seq_res)
  );

  // result register
  i2cm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res_in    (seq_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (obuf_busy),
    .res_out   (out_res)
  );

  assign out_scl_level    = out_res.scl_level;
  assign out_sda_level    = out_res.sda_level;
  assign out_ready_res    = out_res.ready_res;
  assign out_done_res     = out_res.done_res;
  assign out_rx_byte      = out_res.rx_byte;
  assign out_ack_received = out_res.ack_received;
  assign out_start_failed = out_res.start_failed;

endmodule

[tb/i2c_master_byte_engine_tb.sv]
`timescale 1ns / 1ps

import i2cm_pkg::*;

class bus_line_tracker;
  res_t        pending_lines[$];
  int unsigned faults;
  int unsigned shown;
  logic [7:0]  ticks_cfg;
  phase_t      phase;
  logic [7:0]  hold_cnt;
  logic [3:0]  bits_done;
  logic [7:0]  shifter;
  logic [2:0]  cur_cmd;
  logic        scl_drv;
  logic        sda_drv;
  logic        ack_flag;
  logic        busy_flag;
  logic [7:0]  rx_last;

  function new();
    faults    = 0;
    shown     = 0;
    ticks_cfg = TICKS_RESET;
    phase     = PH_IDLE;
    hold_cnt  = 8'd0;
    bits_done = 4'd0;
    shifter   = 8'd0;
    cur_cmd   = CMD_NONE;
    scl_drv   = 1'b1;
    sda_drv   = 1'b1;
    ack_flag  = 1'b0;
    busy_flag = 1'b0;
    rx_last   = 8'd0;
  endfunction

  function bit is_idle();
    return phase == PH_IDLE;
  endfunction

  // lines change in the tick the phase is entered
  function void enter(phase_t p);
    phase    = p;
    hold_cnt = 8'd1;
    case (p)
      ST_SDA1, SP_SDA1, WA_SDA1: sda_drv = 1'b1;
      ST_SCL1, SP_SCL1, WB_SCL1, WA_SCL1, RB_SCL1, RA_SCL1: scl_drv = 1'b1;
      ST_SDA0, SP_SDA0: sda_drv = 1'b0;
      ST_SCL0, SP_SCL0, WB_SCL0, WA_SCL0, RB_SCL0, RA_SCL0, RA_SCL0B: scl_drv = 1'b0;
      WB_SDA: begin
        sda_drv = shifter[7];
        shifter = {shifter[6:0], 1'b0};
      end
      RA_SDA: sda_drv = (cur_cmd == CMD_READ_ACK) ? 1'b0 : 1'b1;
      default: ;
    endcase
  endfunction

  // returns 1 when the command finishes in this tick
  function bit close_phase(logic sda);
    case (phase)
      ST_SDA1: enter(ST_SCL1);
      ST_SCL1: begin
        if (!sda) begin
          busy_flag = 1'b1;
          phase     = PH_IDLE;
          return 1'b1;
        end
        busy_flag = 1'b0;
        enter(ST_SDA0);
      end
      ST_SDA0: enter(ST_SCL0);
      SP_SCL0: enter(SP_SDA0);
      SP_SDA0: enter(SP_SCL1);
      SP_SCL1: enter(SP_SDA1);
      WB_SCL0: enter(WB_SDA);
      WB_SDA:  enter(WB_SCL1);
      WB_SCL1: begin
        bits_done = bits_done + 4'd1;
        if (bits_done < BYTE_BITS) enter(WB_SCL0);
        else enter(WA_SCL0);
      end
      WA_SCL0: enter(WA_SDA1);
      WA_SDA1: enter(WA_SCL1);
      WA_SCL1: begin
        ack_flag = !sda;
        scl_drv  = 1'b0;
        phase    = PH_IDLE;
        return 1'b1;
      end
      RB_SCL0: enter(RB_SCL1);
      RB_SCL1: begin
        shifter   = {shifter[6:0], sda};
        bits_done = bits_done + 4'd1;
        if (bits_done < BYTE_BITS) begin
          enter(RB_SCL0);
        end else begin
          rx_last = shifter;
          enter(RA_SCL0);
        end
      end
      RA_SCL0: enter(RA_SDA);
      RA_SDA:  enter(RA_SCL1);
      RA_SCL1: enter(RA_SCL0B);
      default: begin
        phase = PH_IDLE;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function void take_tick(logic [2:0] cmd, logic [7:0] tx, logic sda);
    res_t       want;
    logic [7:0] lim;
    logic       rdy;
    logic       fin;
    lim = (ticks_cfg == 8'd0) ? 8'd1 : ticks_cfg;
    rdy = 1'b0;
    fin = 1'b0;
    if (phase == PH_IDLE) begin
      rdy = 1'b1;
      if (cmd >= CMD_START && cmd <= CMD_READ_NACK) begin
        cur_cmd   = cmd;
        bits_done = 4'd0;
        case (cmd)
          CMD_START: enter(ST_SDA1);
          CMD_STOP:  enter(SP_SCL0);
          CMD_WRITE: begin
            shifter = tx;
            enter(WB_SCL0);
          end
          default: begin
            sda_drv = 1'b1;
            shifter = 8'd0;
            enter(RB_SCL0);
          end
        endcase
      end
    end else if (hold_cnt < lim) begin
      hold_cnt = hold_cnt + 8'd1;
    end else begin
      fin = close_phase(sda);
    end
    want.scl_level    = scl_drv;
    want.sda_level    = sda_drv;
    want.ready_res    = rdy;
    want.done_res     = fin;
    want.rx_byte      = rx_last;
    want.ack_received = ack_flag;
    want.start_failed = busy_flag;
    pending_lines.push_back(want);
  endfunction

  function void match_lines(res_t got);
    res_t want;
    if (pending_lines.size() == 0) begin
      faults++;
      if (shown < 10) begin
        shown++;
        $display("unexpected result transaction %h at %0t", got, $realtime);
      end
      return;
    end
    want = pending_lines.pop_front();
    if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
        got.ready_res !== want.ready_res || got.done_res !== want.done_res ||
        got.rx_byte !== want.rx_byte || got.ack_received !== want.ack_received ||
        got.start_failed !== want.start_failed) begin
      faults++;
      if (shown < 10) begin
        shown++;
        $display("mismatch at %0t: scl %b/%b sda %b/%b ready %b/%b done %b/%b (exp/act)",
                 $realtime, want.scl_level, got.scl_level, want.sda_level, got.sda_level,
                 want.ready_res, got.ready_res, want.done_res, got.done_res);
        $display("  rx %h/%h ack %b/%b busy %b/%b (exp/act)",
                 want.rx_byte, got.rx_byte, want.ack_received, got.ack_received,
                 want.start_failed, got.start_failed);
      end
    end
  endfunction
endclass

module i2c_master_byte_engine_tb;

  // reserved command codes, the sequencer must ignore them
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // cycles without any transaction before the run is called hung
  localparam int unsigned QUIET_LIMIT = 2000;

  // how the sda input behaves while one command runs
  typedef enum logic [1:0] {
    SDA_LOW,
    SDA_HIGH,
    SDA_MIXED
  } sda_plan_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_command = CMD_NONE;
  logic [7:0] in_tx_byte = 8'd0;
  logic       in_sda_in = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_ready_res;
  logic       out_done_res;
  logic [7:0] out_rx_byte;
  logic       out_ack_received;
  logic       out_start_failed;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  bus_line_tracker lines;
  bit              calm = 1'b0;     // set for the last part: no idling on either side
  int unsigned     stall_left = 0;
  int unsigned     quiet_cycles = 0;

  always #5 clk = ~clk;

  i2c_master_byte_engine u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_tx_byte       (in_tx_byte),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_level    (out_scl_level),
    .out_sda_level    (out_sda_level),
    .out_ready_res    (out_ready_res),
    .out_done_res     (out_done_res),
    .out_rx_byte      (out_rx_byte),
    .out_ack_received (out_ack_received),
    .out_start_failed (out_start_failed),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  // result side: check what was accepted at this edge, then pick the next stall level
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      lines.match_lines({out_scl_level, out_sda_level, out_ready_res, out_done_res,
                         out_rx_byte, out_ack_received, out_start_failed});
    end
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      // burst of stalled cycles, its length drawn at random into stall_left
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // hang detection: counts cycles in which no transaction moves on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic pick_sda(sda_plan_t plan);
    case (plan)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      // mostly released so starts usually find the bus free
      default:  return ($urandom_range(0, 3) != 0);
    endcase
  endfunction

  // one tick transaction: optional sender gap, then hold until accepted
  task automatic push_tick(input logic [2:0] cmd, input logic [7:0] tx, input logic sda);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_tx_byte <= tx;
    in_sda_in  <= sda;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lines.take_tick(cmd, tx, sda);
  endtask

  // issue a command while the sequencer is idle, then clock it to completion
  // commands given while busy are noise that must be ignored
  task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx,
                             input sda_plan_t plan);
    push_tick(cmd, tx, pick_sda(plan));
    while (!lines.is_idle()) begin
      push_tick(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), pick_sda(plan));
    end
  endtask

  // a bus transfer: start, address byte, a few data bytes, stop
  // now and then a lone command instead, to hit odd orderings
  task automatic run_transfer();
    int unsigned n;
    int unsigned k;
    if ($urandom_range(0, 5) == 0) begin
      run_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), SDA_MIXED);
      return;
    end
    run_command(CMD_START, 8'($urandom_range(0, 255)), SDA_MIXED);
    run_command(CMD_WRITE, 8'($urandom_range(0, 255)), SDA_MIXED);
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 2))
        0:       run_command(CMD_WRITE, 8'($urandom_range(0, 255)), SDA_MIXED);
        1:       run_command(CMD_READ_ACK, 8'($urandom_range(0, 255)), SDA_MIXED);
        default: run_command(CMD_READ_NACK, 8'($urandom_range(0, 255)), SDA_MIXED);
      endcase
    end
    run_command(CMD_STOP, 8'($urandom_range(0, 255)), SDA_MIXED);
  endtask

  // phase length write, only once every expected result is back
  task automatic write_phase_ticks(input logic [7:0] value);
    in_valid <= 1'b0;
    while (lines.pending_lines.size() != 0) @(posedge clk);
    // give the last result some margin before the write
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    lines.ticks_cfg = value;
  endtask

  initial begin
    lines = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset phase length: ignored codes while idle, then one slow start on a busy bus
    run_command(CMD_NONE, 8'h00, SDA_HIGH);
    run_command(CMD_RSVD6, 8'hFF, SDA_LOW);
    run_command(CMD_RSVD7, 8'h5A, SDA_HIGH);
    run_command(CMD_START, 8'h00, SDA_LOW);

    // zero phase length behaves as one tick
    write_phase_ticks(8'd0);
    run_command(CMD_START, 8'h00, SDA_LOW);       // bus busy, start fails
    run_command(CMD_START, 8'hFF, SDA_HIGH);      // clears the busy flag
    run_command(CMD_WRITE, 8'h00, SDA_LOW);       // acked
    run_command(CMD_WRITE, 8'hFF, SDA_HIGH);      // nacked
    run_command(CMD_READ_ACK, 8'h00, SDA_HIGH);   // all ones
    run_command(CMD_READ_NACK, 8'hFF, SDA_LOW);   // all zeros
    run_command(CMD_STOP, 8'h00, SDA_HIGH);

    // shortest real phase
    write_phase_ticks(8'd1);
    run_transfer();

    // last part with no idling on either side
    write_phase_ticks(8'd2);
    calm = 1'b1;
    run_command(CMD_START, 8'h00, SDA_HIGH);
    run_command(CMD_WRITE, 8'h96, SDA_MIXED);
    run_command(CMD_STOP, 8'h00, SDA_MIXED);

    in_valid <= 1'b0;
    while (lines.pending_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (lines.faults == 0 && lines.pending_lines.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
